[rtl/lbsd_pkg.sv]
`timescale 1ns / 1ps

package lbsd_pkg;

   // field widths
   localparam int IdxW     = 8;
   localparam int LevelW   = 16;
   localparam int ErrW     = 9;
   localparam int ByteW    = 8;
   localparam int GainW    = 17;
   localparam int CsrAddrW = 1;

   // strip size and state memory geometry
   localparam int LedCount = 144;
   localparam int LedDepth = (LedCount < (2 ** IdxW)) ? LedCount : (2 ** IdxW);
   localparam int LedAddrW = (LedDepth <= 2) ? 1 : $clog2(LedDepth);

   // stream words
   localparam int ReqDataW = IdxW + LevelW + 3 * ByteW;
   localparam int RspDataW = IdxW + 4 * ByteW;

   // fixed-point constants
   localparam int ScaledW = LevelW + ByteW;
   localparam logic [GainW-1:0]   GainOne     = 17'h10000;
   localparam logic [LevelW-1:0]  SnapLimit   = 16'd514;
   localparam logic [ScaledW-1:0] DitherFloor = 24'd196608;
   localparam logic [ScaledW-1:0] ScaledMax   = 24'hFF0000;

   // result queue, depth a power of two
   localparam int FifoDepth = 8;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   // register indexes
   localparam logic [CsrAddrW-1:0] CsrAttackGain  = 1'b0;
   localparam logic [CsrAddrW-1:0] CsrReleaseGain = 1'b1;

   typedef struct packed {
      logic [LevelW-1:0]      level;
      logic signed [ErrW-1:0] err;
   } led_state_type;

   localparam int StateW = $bits(led_state_type);

   typedef struct packed {
      logic             last;
      logic [ByteW-1:0] level_byte;
      logic [ByteW-1:0] blue_byte;
      logic [ByteW-1:0] red_byte;
      logic [ByteW-1:0] green_byte;
      logic [IdxW-1:0]  slot;
   } rsp_word_type;

endpackage

[rtl/lbsd_ram.sv]
`timescale 1ns / 1ps

module lbsd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrW = (Depth <= 2) ? 1 : $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lbsd_fifo.sv]
`timescale 1ns / 1ps

module lbsd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  lbsd_pkg::rsp_word_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lbsd_pkg::rsp_word_type out_data
);

   import lbsd_pkg::*;

   rsp_word_type        entry_ff [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0] count_ff, count_in;
   logic                pop;

   // no overflow check: the caller holds back input by credit
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FifoPtrW'(in_valid);
      rd_ptr_in = rd_ptr_ff + FifoPtrW'(pop);
      count_in  = count_ff + FifoCntW'(in_valid) - FifoCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/led_brightness_smooth_dither.sv]
`timescale 1ns / 1ps

// Per-LED output stage. Each req word names an LED and brings its wanted brightness and base
// colour; the block smooths the brightness per LED (attack gain when rising, release gain when
// falling, snap to zero at or below 2/255), quantises it to a byte with per-LED error-feedback
// dithering from 3.0 up, scales G, R, B by that byte and returns one rsp word per req word, in
// order. One word is taken every clock while req_tready is high; its result passes through
// stages 1 to 4 and the result queue before it is valid on rsp. Smoothed level and dither
// error sit in one state memory with a registered read; the read-modify-write loop through
// it needs the first of two consecutive words for the same LED index out of stage 1 before
// the second is taken, so req_tready drops while the first is in stage 1. Up to eight words
// are in flight, set by the depth of the result queue. The state is zero after reset through
// per-entry valid bits, so there is no clearing pass. Gains above 1.0 act as 1.0; an index
// at or above the strip length is processed with zero state, leaves the memory untouched and
// still returns a result. Gains must be written only while the block is idle; the block itself does not enforce it.

module led_brightness_smooth_dither (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: led_index, target_level, base_red, base_green, base_blue
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lbsd_pkg::ReqDataW-1:0]     req_tdata,
   input  logic                              req_tlast,
   // rsp_tdata: led_slot, green_byte, red_byte, blue_byte, level_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lbsd_pkg::RspDataW-1:0]     rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_wen,
   input  logic [lbsd_pkg::CsrAddrW-1:0]     csr_addr,
   input  logic [lbsd_pkg::GainW-1:0]        csr_wdata
);

   import lbsd_pkg::*;

   localparam int ProdW = LevelW + 1 + GainW + 1;
   localparam int StepW = ProdW - LevelW;
   localparam int SumW  = StepW + 1;
   localparam int WideW = ScaledW + 2;
   localparam logic signed [ProdW-1:0] ProdHalf = ProdW'(32768);
   localparam logic [ScaledW:0]        ByteHalf = (ScaledW + 1)'(32768);

   typedef struct packed {
      logic              valid;
      logic              in_range;
      logic              mem_valid;
      logic [IdxW-1:0]   idx;
      logic [LevelW-1:0] target;
      logic [ByteW-1:0]  red;
      logic [ByteW-1:0]  green;
      logic [ByteW-1:0]  blue;
      logic              last;
   } s1_type;

   typedef struct packed {
      logic                    valid;
      logic                    in_range;
      logic [IdxW-1:0]         idx;
      logic [LevelW-1:0]       level;
      logic signed [ErrW-1:0]  err;
      logic signed [ProdW-1:0] prod;
      logic [ByteW-1:0]        red;
      logic [ByteW-1:0]        green;
      logic [ByteW-1:0]        blue;
      logic                    last;
   } s2_type;

   typedef struct packed {
      logic                   valid;
      logic                   in_range;
      logic [IdxW-1:0]        idx;
      logic [LevelW-1:0]      level;
      logic signed [ErrW-1:0] err;
      logic [ByteW-1:0]       red;
      logic [ByteW-1:0]       green;
      logic [ByteW-1:0]       blue;
      logic                   last;
   } s3_type;

   typedef struct packed {
      logic                   valid;
      logic                   in_range;
      logic [IdxW-1:0]        idx;
      logic [LevelW-1:0]      level;
      logic signed [ErrW-1:0] err;
      logic [ByteW-1:0]       level_byte;
      logic [ByteW-1:0]       red;
      logic [ByteW-1:0]       green;
      logic [ByteW-1:0]       blue;
      logic                   last;
   } s4_type;

   // (c*b + 127) / 255 without a divider: exact for quotients up to 255
   function automatic logic [ByteW-1:0] scale_chan(input logic [ByteW-1:0] c,
                                                   input logic [ByteW-1:0] b);
      logic [2*ByteW-1:0] x;
      logic [2*ByteW-1:0] t;
      begin
         x = c * b + (2 * ByteW)'(127);
         t = x + {{ByteW{1'b0}}, x[2*ByteW-1:ByteW]} + (2 * ByteW)'(1);
         return t[2*ByteW-1:ByteW];
      end
   endfunction

   logic [GainW-1:0]    attack_ff, attack_in;
   logic [GainW-1:0]    release_ff, release_in;
   logic [FifoCntW-1:0] occ_ff, occ_in;
   logic [LedDepth-1:0] entry_valid_ff, entry_valid_in;
   s1_type              s1_ff, s1_in;
   s2_type              s2_ff, s2_in;
   s3_type              s3_ff, s3_in;
   s4_type              s4_ff, s4_in;

   logic [IdxW-1:0]     req_idx;
   logic                req_in_range;
   logic [LedAddrW-1:0] req_addr;
   logic                hazard;
   logic                accept;
   logic                rsp_fire;

   led_state_type       ram_rd;
   led_state_type       ram_wr;
   logic                ram_wr_en;
   logic [LedAddrW-1:0] ram_wr_addr;

   led_state_type       cur;
   logic                fwd3, fwd4;
   logic [GainW-1:0]    gain_raw, gain;
   logic signed [LevelW:0]  diff;
   logic signed [GainW:0]   gain_s;

   logic signed [ProdW-1:0] prod_rnd;
   logic signed [StepW-1:0] step;
   logic signed [SumW-1:0]  lvl_sum;
   logic [LevelW-1:0]       lvl_clamp;

   logic [ScaledW-1:0]      scaled;
   logic                    dither_on;
   logic signed [WideW-1:0] w_raw;
   logic [ScaledW-1:0]      w_clamp;
   logic [ScaledW:0]        w_rnd;
   logic [ScaledW:0]        v_rnd;
   logic [ByteW:0]          q_dith;
   logic [ByteW-1:0]        b_dith;
   logic signed [WideW-1:0] resid;
   logic signed [ErrW-1:0]  err_new;
   logic [ByteW-1:0]        level_byte;

   rsp_word_type            fifo_in;
   rsp_word_type            fifo_out;

   // ---------------------------------------------------------------- config
   always_comb begin
      attack_in  = attack_ff;
      release_in = release_ff;
      if (csr_wen) begin
         case (csr_addr)
            CsrAttackGain:  attack_in  = csr_wdata;
            CsrReleaseGain: release_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- intake
   assign req_idx      = req_tdata[IdxW-1:0];
   assign req_in_range = (32'(req_idx) < 32'(LedCount));
   assign req_addr     = req_idx[LedAddrW-1:0];

   // same LED as the word in stage 1: its new level is not ready yet
   assign hazard     = s1_ff.valid && (s1_ff.idx == req_idx);
   // credit: every word in flight has a queue slot waiting for it
   assign req_tready = !reset && (occ_ff < FifoCntW'(FifoDepth)) && !hazard;
   assign accept     = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign occ_in = occ_ff + FifoCntW'(accept) - FifoCntW'(rsp_fire);

   always_comb begin
      s1_in           = s1_ff;
      s1_in.valid     = accept;
      s1_in.in_range  = req_in_range;
      s1_in.mem_valid = req_in_range && entry_valid_ff[req_addr];
      s1_in.idx       = req_idx;
      s1_in.target    = req_tdata[IdxW+LevelW-1:IdxW];
      s1_in.red       = req_tdata[IdxW+LevelW+ByteW-1:IdxW+LevelW];
      s1_in.green     = req_tdata[IdxW+LevelW+2*ByteW-1:IdxW+LevelW+ByteW];
      s1_in.blue      = req_tdata[IdxW+LevelW+3*ByteW-1:IdxW+LevelW+2*ByteW];
      s1_in.last      = req_tlast;
   end

   lbsd_ram #(
      .Width (StateW),
      .Depth (LedDepth)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr),
      .rd_en   (accept && req_in_range),
      .rd_addr (req_addr),
      .rd_data (ram_rd)
   );

   // ---------------------------------------------------------------- stage 1
   // Latest state: stage 3 writes at the coming edge, stage 4 wrote at the read edge
   // (read-first), older writes are in the memory. Stage 2 is kept out by the hazard stall.
   assign fwd3 = s3_ff.valid && s3_ff.in_range && (s3_ff.idx == s1_ff.idx);
   assign fwd4 = s4_ff.valid && s4_ff.in_range && (s4_ff.idx == s1_ff.idx);

   always_comb begin
      if (!s1_ff.in_range) begin
         cur = '0;
      end else if (fwd3) begin
         cur.level = s3_ff.level;
         cur.err   = err_new;
      end else if (fwd4) begin
         cur.level = s4_ff.level;
         cur.err   = s4_ff.err;
      end else if (s1_ff.mem_valid) begin
         cur = ram_rd;
      end else begin
         cur = '0;
      end
   end

   // equal target takes the release gain; step is zero then anyway
   assign gain_raw = (s1_ff.target > cur.level) ? attack_ff : release_ff;
   assign gain     = (gain_raw > GainOne) ? GainOne : gain_raw;
   assign diff     = $signed({1'b0, s1_ff.target}) - $signed({1'b0, cur.level});
   assign gain_s   = $signed({1'b0, gain});

   always_comb begin
      s2_in          = s2_ff;
      s2_in.valid    = s1_ff.valid;
      s2_in.in_range = s1_ff.in_range;
      s2_in.idx      = s1_ff.idx;
      s2_in.level    = cur.level;
      s2_in.err      = cur.err;
      s2_in.prod     = diff * gain_s;
      s2_in.red      = s1_ff.red;
      s2_in.green    = s1_ff.green;
      s2_in.blue     = s1_ff.blue;
      s2_in.last     = s1_ff.last;
   end

   // ---------------------------------------------------------------- stage 2
   // step rounds half up: floor((d*g + 0.5) / 1.0)
   assign prod_rnd = s2_ff.prod + ProdHalf;
   assign step     = prod_rnd[ProdW-1:LevelW];
   assign lvl_sum  = $signed({{(SumW-LevelW){1'b0}}, s2_ff.level})
                   + $signed({step[StepW-1], step});

   always_comb begin
      if (lvl_sum < 0) begin
         lvl_clamp = '0;
      end else if (lvl_sum > $signed(SumW'(16'hFFFF))) begin
         lvl_clamp = '1;
      end else begin
         lvl_clamp = lvl_sum[LevelW-1:0];
      end
   end

   always_comb begin
      s3_in          = s3_ff;
      s3_in.valid    = s2_ff.valid;
      s3_in.in_range = s2_ff.in_range;
      s3_in.idx      = s2_ff.idx;
      s3_in.level    = (lvl_clamp <= SnapLimit) ? '0 : lvl_clamp;
      s3_in.err      = s2_ff.err;
      s3_in.red      = s2_ff.red;
      s3_in.green    = s2_ff.green;
      s3_in.blue     = s2_ff.blue;
      s3_in.last     = s2_ff.last;
   end

   // ---------------------------------------------------------------- stage 3
   // level * 255 on a 0..255 scale with 16 fractional bits
   assign scaled    = {s3_ff.level, {ByteW{1'b0}}} - {{ByteW{1'b0}}, s3_ff.level};
   assign dither_on = (scaled >= DitherFloor);

   // error carries 8 fractional bits, so it lines up at bit 8
   assign w_raw = $signed({2'b00, scaled})
                + $signed({{(WideW-ErrW-ByteW){s3_ff.err[ErrW-1]}}, s3_ff.err, {ByteW{1'b0}}});

   always_comb begin
      if (w_raw < 0) begin
         w_clamp = '0;
      end else if (w_raw > $signed({2'b00, ScaledMax})) begin
         w_clamp = ScaledMax;
      end else begin
         w_clamp = w_raw[ScaledW-1:0];
      end
   end

   assign w_rnd  = {1'b0, w_clamp} + ByteHalf;
   assign q_dith = w_rnd[ScaledW:LevelW];
   assign b_dith = (q_dith > (ByteW + 1)'(255)) ? '1 : q_dith[ByteW-1:0];
   assign resid  = $signed({2'b00, w_clamp})
                 - $signed({2'b00, b_dith, {LevelW{1'b0}}})
                 + $signed(WideW'(128));
   assign v_rnd  = {1'b0, scaled} + ByteHalf;

   always_comb begin
      if (dither_on) begin
         level_byte = b_dith;
         err_new    = resid[ErrW+ByteW-1:ByteW];
      end else begin
         level_byte = v_rnd[ScaledW-1:LevelW];
         err_new    = '0;
      end
   end

   assign ram_wr_en    = s3_ff.valid && s3_ff.in_range;
   assign ram_wr_addr  = s3_ff.idx[LedAddrW-1:0];
   assign ram_wr.level = s3_ff.level;
   assign ram_wr.err   = err_new;

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (ram_wr_en) begin
         entry_valid_in[ram_wr_addr] = 1'b1;
      end
   end

   always_comb begin
      s4_in            = s4_ff;
      s4_in.valid      = s3_ff.valid;
      s4_in.in_range   = s3_ff.in_range;
      s4_in.idx        = s3_ff.idx;
      s4_in.level      = s3_ff.level;
      s4_in.err        = err_new;
      s4_in.level_byte = level_byte;
      s4_in.red        = s3_ff.red;
      s4_in.green      = s3_ff.green;
      s4_in.blue       = s3_ff.blue;
      s4_in.last       = s3_ff.last;
   end

   // ---------------------------------------------------------------- stage 4
   always_comb begin
      fifo_in.last       = s4_ff.last;
      fifo_in.level_byte = s4_ff.level_byte;
      fifo_in.blue_byte  = scale_chan(s4_ff.blue, s4_ff.level_byte);
      fifo_in.red_byte   = scale_chan(s4_ff.red, s4_ff.level_byte);
      fifo_in.green_byte = scale_chan(s4_ff.green, s4_ff.level_byte);
      fifo_in.slot       = s4_ff.idx;
   end

   lbsd_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_ff.valid),
      .in_data   (fifo_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (fifo_out)
   );

   assign rsp_tdata = {fifo_out.level_byte, fifo_out.blue_byte, fifo_out.red_byte,
                       fifo_out.green_byte, fifo_out.slot};
   assign rsp_tlast = fifo_out.last;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff      <= GainOne;
         release_ff     <= GainOne;
         occ_ff         <= '0;
         entry_valid_ff <= '0;
      end else begin
         attack_ff      <= attack_in;
         release_ff     <= release_in;
         occ_ff         <= occ_in;
         entry_valid_ff <= entry_valid_in;
      end
   end

endmodule

[rtl/lbsd_checker.sv]
`timescale 1ns / 1ps

module lbsd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [lbsd_pkg::ReqDataW-1:0] req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [lbsd_pkg::RspDataW-1:0] rsp_tdata,
   input logic                          rsp_tlast
);

   import lbsd_pkg::*;

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word valid right after reset");

   // ready again as soon as reset drops
   a_ready_after_reset: assert property (@(posedge clock) $fell(reset) |-> req_tready)
      else $error("req not ready after reset");

   // a word for the same LED right after an accepted one must be held back
   a_same_led_stall: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1
      (req_tvalid && (req_tdata[IdxW-1:0] == $past(req_tdata[IdxW-1:0])))
      |-> !req_tready)
      else $error("back-to-back word for the same LED accepted");

   // a dark LED shows no colour
   a_dark_led: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[IdxW+4*ByteW-1:IdxW+3*ByteW] == '0))
      |-> (rsp_tdata[IdxW+3*ByteW-1:IdxW] == '0))
      else $error("colour bytes non-zero at zero level");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
      |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("rsp word changed while stalled");

endmodule

bind led_brightness_smooth_dither lbsd_checker u_lbsd_checker (.*);

[tb/led_brightness_smooth_dither_tb.sv]
`timescale 1ns / 1ps

// Checks the LED output stage against a cycle-free predictor of its per-LED smoothing,
// snapping, dithering and colour scaling. Directed words first, then random frames
// over a roving window of LEDs under several gain settings.

module led_brightness_smooth_dither_tb;
   import lbsd_pkg::*;

   localparam int CycleLimit = 500000;   // watchdog limit; a correct run ends well inside it
   localparam int SettleCycles = 8;      // covers stages 1 to 4 and the result queue, plus margin

   // one input word as the predictor sees it
   typedef struct packed {
      logic [IdxW-1:0]   idx;
      logic [LevelW-1:0] level;
      logic [ByteW-1:0]  red;
      logic [ByteW-1:0]  green;
      logic [ByteW-1:0]  blue;
      logic              last;
   } led_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // req_tdata, lowest bit up: led_index, target_level, base_red, base_green, base_blue
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata = '0;
   logic                  req_tlast = 1'b0;
   // rsp_tdata, lowest bit up: led_slot, green_byte, red_byte, blue_byte, level_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspDataW-1:0]   rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wen = 1'b0;
   logic [CsrAddrW-1:0]   csr_addr = CsrAttackGain;
   logic [GainW-1:0]      csr_wdata = '0;

   led_brightness_smooth_dither dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor state: its own copy of the gains and of the per-LED memory
   // ---------------------------------------------------------------------------------------
   longint attack_gain_m = 65536;
   longint release_gain_m = 65536;
   int     model_level [LedCount];   // smoothed level, 16 fractional bits
   int     model_err   [LedCount];   // dither error, 1/256 of a level step

   led_word_type  pending_words [$];   // filled by the stimulus, emptied by the driver
   rsp_word_type  expected_pixels [$]; // oldest first

   int  words_queued = 0;
   int  words_sent = 0;
   int  pixels_checked = 0;
   int  errors = 0;
   int  cycle_count = 0;
   int  frame_base = 0;
   int  gain_settings = 1;
   bit  quiet = 1'b0;                  // no idling on either side while set

   function automatic logic [ByteW-1:0] scale_by(input logic [ByteW-1:0] c, input longint lvl);
      longint t;
      t = (longint'(c) * lvl + 127) / 255;
      return t[ByteW-1:0];
   endfunction

   // Works out the pixel word for one accepted word and updates the LED's state.
   function automatic rsp_word_type predict_pixel(input led_word_type w);
      rsp_word_type px;
      longint s, e, gain, d, v, acc, b;
      bit in_strip;
      in_strip = (w.idx < LedCount);
      s = 0;
      e = 0;
      // LEDs past the strip end run from zero state and leave the memory alone
      if (in_strip) begin
         s = model_level[w.idx];
         e = model_err[w.idx];
      end
      // equal target falls to the release gain, with a zero step anyway
      gain = (longint'(w.level) > s) ? attack_gain_m : release_gain_m;
      if (gain > 65536) gain = 65536;
      d = longint'(w.level) - s;
      s = s + ((d * gain + 32768) >>> 16);   // floor division, halves round up
      if (s < 0) s = 0;
      if (s > 65535) s = 65535;
      if (s <= longint'(SnapLimit)) s = 0;   // 2/255 and below snaps to dark
      v = s * 255;
      if (v >= 3 * 65536) begin
         // error-feedback rounding
         acc = v + e * 256;
         if (acc < 0) acc = 0;
         if (acc > 255 * 65536) acc = 255 * 65536;
         b = (acc + 32768) >>> 16;
         if (b > 255) b = 255;
         e = (acc - b * 65536 + 128) >>> 8;
      end else begin
         // plain rounding, stored error cleared
         b = (v + 32768) >>> 16;
         e = 0;
      end
      if (in_strip) begin
         model_level[w.idx] = int'(s);
         model_err[w.idx] = int'(e);
      end
      px.slot = w.idx;
      px.green_byte = scale_by(w.green, b);
      px.red_byte = scale_by(w.red, b);
      px.blue_byte = scale_by(w.blue, b);
      px.level_byte = b[ByteW-1:0];
      px.last = w.last;
      return px;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: one word from the pending queue at a time, held until taken
   // ---------------------------------------------------------------------------------------
   led_word_type cur_word;
   int unsigned  req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_pixels.push_back(predict_pixel(cur_word));
            words_sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               cur_word = pending_words.pop_front();
               req_tdata <= {cur_word.blue, cur_word.green, cur_word.red,
                             cur_word.level, cur_word.idx};
               req_tlast <= cur_word.last;
               req_tvalid <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: random back-pressure, each pixel word checked against the oldest prediction
   // ---------------------------------------------------------------------------------------
   int unsigned rsp_stall = 0;

   task automatic check_field(input string name, input logic [ByteW-1:0] want,
                              input logic [ByteW-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'({rsp_tlast, rsp_tdata});
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t: unexpected pixel word, got slot %0d level %0d", $time,
                        got.slot, got.level_byte);
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked++;
               check_field("led_slot", want.slot, got.slot);
               check_field("green_byte", want.green_byte, got.green_byte);
               check_field("red_byte", want.red_byte, got.red_byte);
               check_field("blue_byte", want.blue_byte, got.blue_byte);
               check_field("level_byte", want.level_byte, got.level_byte);
               check_field("frame_last", {7'd0, want.last}, {7'd0, got.last});
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) < 3) rsp_stall <= pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   task automatic send(input logic [IdxW-1:0] idx, input logic [LevelW-1:0] level,
                       input logic [ByteW-1:0] red, input logic [ByteW-1:0] green,
                       input logic [ByteW-1:0] blue, input logic last);
      led_word_type w;
      w.idx = idx;
      w.level = level;
      w.red = red;
      w.green = green;
      w.blue = blue;
      w.last = last;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // sender holds off until every word is taken and every pixel is back
   task automatic drain();
      while (words_sent != words_queued || expected_pixels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // gains change only while the block is idle; the predictor follows at once
   task automatic set_gains(input logic [GainW-1:0] atk, input logic [GainW-1:0] rel);
      drain();
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= CsrAttackGain;
      csr_wdata <= atk;
      @(posedge clock);
      csr_addr <= CsrReleaseGain;
      csr_wdata <= rel;
      @(posedge clock);
      csr_wen <= 1'b0;
      attack_gain_m = atk;
      release_gain_m = rel;
      gain_settings++;
   endtask

   function automatic logic [ByteW-1:0] colour();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) return 8'd0;
      if (r < 4) return 8'd255;
      return ByteW'($urandom_range(0, 255));
   endfunction

   function automatic logic [GainW-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return 17'd1;
         2: return 17'd65535;
         3: return GainOne;
         4: return 17'h1FFFF;
         5: return GainW'($urandom_range(65537, 131071));
         default: return GainW'($urandom_range(0, 65536));
      endcase
   endfunction

   // Mostly frames of consecutive LEDs ending on the frame marker, often over the same
   // window again so smoothing and dither error build up; the rest is stray words.
   task automatic random_run(input int n_words);
      int done, len, k, profile;
      logic [LevelW-1:0] lvl;
      done = 0;
      while (done < n_words) begin
         if ($urandom_range(0, 4) == 0) begin
            send(IdxW'($urandom_range(0, 255)), LevelW'($urandom), colour(), colour(),
                 colour(), 1'($urandom_range(0, 1)));
            done++;
         end else begin
            if ($urandom_range(0, 2) == 0) frame_base = int'($urandom_range(0, LedCount - 1));
            len = int'($urandom_range(1, 12));
            profile = int'($urandom_range(0, 3));
            lvl = LevelW'($urandom);
            for (k = 0; k < len; k++) begin
               case (profile)
                  0: lvl = LevelW'($urandom);
                  1: lvl = LevelW'($urandom_range(0, 1500));     // around snap and dither floor
                  2: lvl = LevelW'($urandom_range(60000, 65535));
                  default: ;                                     // flat frame
               endcase
               // window may run past the strip end
               send(IdxW'(frame_base + k), lvl, colour(), colour(), colour(), k == len - 1);
               done++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int ph;
      for (int i = 0; i < LedCount; i++) begin
         model_level[i] = 0;
         model_err[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset gains of 1.0: target taken at once
      send(8'd0, 16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b0);   // full white, dither path
      send(8'd0, 16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b0);         // same LED back to back
      send(8'd143, 16'd0, 8'd255, 8'd255, 8'd255, 1'b1);    // last LED, dark
      send(8'd144, 16'd40000, 8'd200, 8'd100, 8'd50, 1'b0); // just past the strip
      send(8'd255, 16'hFFFF, 8'd170, 8'd85, 8'd255, 1'b1);  // highest index
      send(8'd1, 16'd514, 8'd255, 8'd255, 8'd255, 1'b0);    // snaps to zero
      send(8'd1, 16'd515, 8'd255, 8'd255, 8'd255, 1'b0);    // just above snap
      send(8'd2, 16'd771, 8'd255, 8'd128, 8'd1, 1'b0);      // just under dither floor
      send(8'd2, 16'd772, 8'd255, 8'd128, 8'd1, 1'b0);      // just over it
      send(8'd2, 16'd772, 8'd255, 8'd128, 8'd1, 1'b0);      // equal target
      send(8'd3, 16'd32768, 8'd18, 8'd240, 8'd99, 1'b0);
      send(8'd3, 16'd0, 8'd18, 8'd240, 8'd99, 1'b1);        // falling to dark

      // gain above one on attack, frozen release
      set_gains(17'h1FFFF, 17'd0);
      send(8'd4, 16'd30000, 8'd255, 8'd255, 8'd255, 1'b0);
      send(8'd4, 16'd10, 8'd255, 8'd255, 8'd255, 1'b0);
      send(8'd4, 16'd60000, 8'd255, 8'd255, 8'd255, 1'b1);

      // frozen attack, release above one
      set_gains(17'd0, 17'h1FFFF);
      send(8'd5, 16'd40000, 8'd255, 8'd255, 8'd255, 1'b0);
      send(8'd4, 16'd0, 8'd255, 8'd255, 8'd255, 1'b1);

      // fractional gains: dither error carries from word to word on one LED
      set_gains(17'd32768, 17'd16384);
      repeat (4) send(8'd6, 16'd1000, 8'd255, 8'd77, 8'd200, 1'b0);
      send(8'd6, 16'd40000, 8'd255, 8'd77, 8'd200, 1'b0);
      send(8'd6, 16'd40000, 8'd255, 8'd77, 8'd200, 1'b0);
      send(8'd6, 16'd0, 8'd255, 8'd77, 8'd200, 1'b1);

      // random part, a fresh gain setting per phase; two phases run without idling
      for (ph = 0; ph < 8; ph++) begin
         set_gains(pick_gain(), pick_gain());
         quiet = (ph == 2 || ph == 5);
         random_run(75);
      end
      drain();
      quiet = 1'b0;

      $display("Summary: %0d pixel words checked over %0d gain settings,", pixels_checked,
               gain_settings);
      $display("  directed extremes, snap and dither edges, then random LED frames.");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/lbsd_pkg.sv
rtl/lbsd_ram.sv
rtl/lbsd_fifo.sv
rtl/led_brightness_smooth_dither.sv
rtl/lbsd_checker.sv
tb/led_brightness_smooth_dither_tb.sv
